### design/stk_pkg.sv
`timescale 1ns / 1ps
package stk_pkg;

	// Fixed field widths of the transaction payloads.
	localparam int unsigned TAG_W  = 24;
	localparam int unsigned KEY_W  = 16;
	localparam int unsigned IDX_W  = 4;
	localparam int unsigned SLOT_W = 5;

	// Operation codes.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [TAG_W-1:0]  tag_chars;
		logic [KEY_W-1:0]  primary_key;
		logic [KEY_W-1:0]  secondary_key;
		logic [IDX_W-1:0]  read_index;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
		logic [TAG_W-1:0]  out_tag_chars;
		logic [KEY_W-1:0]  out_primary_key;
		logic [KEY_W-1:0]  out_secondary_key;
	} rsp_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [KEY_W-1:0] pri;
		logic [KEY_W-1:0] sec;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
	} ctl_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} ctl_state_t;

endpackage

### design/stk_ctrl.sv
`timescale 1ns / 1ps
module stk_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	output stk_pkg::ctl_cmd_t cmd
);
	import stk_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;
	logic       done_q;

	// Capture a transaction in idle, then execute it in ST_EXEC and return to idle.
	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and result strobe registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

### design/stk_datapath.sv
`timescale 1ns / 1ps
module stk_datapath #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  stk_pkg::ctl_cmd_t cmd,
	input  stk_pkg::req_t     req,
	output stk_pkg::rsp_t     rsp
);
	import stk_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned XW = (AW > IDX_W) ? AW : IDX_W;

	req_t            req_q;
	rsp_t            rsp_q;
	logic [CW-1:0]   count_q;
	entry_t          entry_q [CAPACITY];
	entry_t          entry_d [CAPACITY];
	entry_t          new_entry;
	logic [CAPACITY-1:0] keep;
	logic [CAPACITY-1:0] hit;
	logic [CW-1:0]   slot_enc;
	logic [CW-1:0]   slot_w;
	logic            ins_ok;
	logic            do_ins;
	logic [XW-1:0]   rd_ext;
	logic [AW-1:0]   rd_addr;
	logic            rd_hit;

	assign new_entry.tag = req_q.tag_chars;
	assign new_entry.pri = req_q.primary_key;
	assign new_entry.sec = req_q.secondary_key;

	// Compare-and-shift cells. The table stays sorted with valid entries first,
	// so "keep" is a prefix: an entry stays where it is when it ranks above the
	// new keys, or when it is the first entry equal to them.
	for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
		logic valid;
		logic gt;
		logic eq;
		logic keep_prev;
		logic gt_prev;

		assign valid = (CW'(j) < count_q);
		assign gt    = (entry_q[j].pri > new_entry.pri) ||
		               ((entry_q[j].pri == new_entry.pri) && (entry_q[j].sec > new_entry.sec));
		assign eq    = (entry_q[j].pri == new_entry.pri) && (entry_q[j].sec == new_entry.sec);

		if (j == 0) begin : g_first
			assign keep_prev = 1'b1;
			assign gt_prev   = 1'b1;
		end else begin : g_rest
			assign keep_prev = keep[j-1];
			assign gt_prev   = g_cell[j-1].valid & g_cell[j-1].gt;
		end

		assign keep[j] = valid && (gt || (eq && gt_prev));
		assign hit[j]  = keep_prev && !keep[j];

		// Next contents of this cell on an insert.
		if (j == 0) begin : g_next0
			assign entry_d[j] = keep[j] ? entry_q[j] : new_entry;
		end else begin : g_nextn
			assign entry_d[j] = keep[j] ? entry_q[j] :
			                    (hit[j] ? new_entry : entry_q[j-1]);
		end
	end

	// Encode the one-hot insert position.
	always_comb begin
		slot_enc = '0;
		for (int unsigned j = 0; j < CAPACITY; j++) begin
			if (hit[j]) begin
				slot_enc = slot_enc | CW'(j);
			end
		end
	end

	assign ins_ok = !keep[CAPACITY-1];
	assign slot_w = ins_ok ? slot_enc : CW'(CAPACITY);
	assign do_ins = cmd.exec && (req_q.opcode == OP_INSERT) && ins_ok;

	// Read address and range check.
	assign rd_ext  = XW'(req_q.read_index);
	assign rd_addr = rd_ext[AW-1:0];
	assign rd_hit  = (32'(req_q.read_index) < 32'(count_q));

	// Request capture and response formation.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.exec) begin
			if (req_q.opcode == OP_INSERT) begin
				rsp_q.found             <= ins_ok;
				rsp_q.slot              <= SLOT_W'(slot_w);
				rsp_q.out_tag_chars     <= '0;
				rsp_q.out_primary_key   <= '0;
				rsp_q.out_secondary_key <= '0;
			end else begin
				rsp_q.found             <= rd_hit;
				rsp_q.slot              <= SLOT_W'(req_q.read_index);
				rsp_q.out_tag_chars     <= rd_hit ? entry_q[rd_addr].tag : '0;
				rsp_q.out_primary_key   <= rd_hit ? entry_q[rd_addr].pri : '0;
				rsp_q.out_secondary_key <= rd_hit ? entry_q[rd_addr].sec : '0;
			end
		end
	end

	// Table contents shift on an accepted insert.
	always_ff @(posedge clk) begin
		if (do_ins) begin
			for (int unsigned j = 0; j < CAPACITY; j++) begin
				entry_q[j] <= entry_d[j];
			end
		end
	end

	// Entry count saturates at capacity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_ins && (count_q != CW'(CAPACITY))) begin
			count_q <= count_q + CW'(1);
		end
	end

	assign rsp = rsp_q;

endmodule

### design/sorted_top_k_table_unit.sv
`timescale 1ns / 1ps
// The accepting edge moves the controller to its exec state, which registers
// the result and the strobe done together; the result is taken while done is high.
// The controller captures the transaction in idle and the compare-and-shift row
// executes it in the next cycle, with busy high; a new insert or read waits for idle.
// Reset clears the controller and the entry count; table contents need no reset.
// Results show for one cycle on done and the receiver cannot stall them.
module sorted_top_k_table_unit #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  stk_pkg::req_t req,
	output logic          done,
	output stk_pkg::rsp_t rsp
);
	import stk_pkg::*;

	ctl_cmd_t cmd;

	stk_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	stk_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

### design/stk_checker.sv
`timescale 1ns / 1ps
module stk_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input stk_pkg::rsp_t rsp
);
	import stk_pkg::*;

	// An accepted transaction makes the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted transaction");

	// Each accepted transaction raises the result strobe after its exec state.
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("result strobe missing two cycles after accept");

	// Busy lasts a single cycle.
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	// A result never comes without a preceding busy cycle.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an executed transaction");

	// A result without found carries zero data.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.found) |-> ((rsp.out_tag_chars == '0) &&
		(rsp.out_primary_key == '0) && (rsp.out_secondary_key == '0)))
		else $error("nonzero data on a result without found");

endmodule

bind sorted_top_k_table_unit stk_checker u_chk (.*);
